// ===== hdl/twr_pkg.sv =====
// Shared types and constants of the text-mode terminal writer.
// Used by the front, back and top-level modules; depends on nothing.
`default_nettype none

package twr_pkg;

    // Widths of the item fields and of one stored cell.
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int CELL_W     = CHAR_W + ATTR_W;
    localparam int ROW_PORT_W = 5;
    localparam int COL_PORT_W = 7;

    // Control characters and fixed values.
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;
    localparam logic [CELL_W-1:0] RESET_CELL   = {RESET_ATTR, CH_SPACE};
    localparam int                TAB_STEP     = 4;

    // Operation field codes.
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Command kinds produced by the front end.
    localparam int                KIND_W        = 3;
    localparam logic [KIND_W-1:0] CMD_PUT       = 3'd0;
    localparam logic [KIND_W-1:0] CMD_NEWLINE   = 3'd1;
    localparam logic [KIND_W-1:0] CMD_TAB       = 3'd2;
    localparam logic [KIND_W-1:0] CMD_BACKSPACE = 3'd3;
    localparam logic [KIND_W-1:0] CMD_READ      = 3'd4;
    localparam logic [KIND_W-1:0] CMD_READ_OUT  = 3'd5;

    // Command queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // Register file: byte address bits and register index.
    localparam int                     PADDR_W  = 3;
    localparam int                     REGIDX_W = PADDR_W - 2;
    localparam logic [REGIDX_W-1:0]    REG_ATTR = 1'b0;
    localparam int                     PDATA_W  = 32;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [CHAR_W-1:0]     char_code;
        logic [ROW_PORT_W-1:0] read_row;
        logic [COL_PORT_W-1:0] read_column;
    } cmd_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } eng_status_t;

endpackage

`default_nettype wire

// ===== hdl/twr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
`default_nettype none

module twr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] waddr,
    input  wire  [WIDTH-1:0]         wdata,
    input  wire  [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/twr_front.sv =====
// Front end: accepts items, sorts them into command kinds and queues them.
// Depends on twr_pkg for the command type and codes.
`default_nettype none

module twr_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  start,
    output logic                                 busy,
    input  wire                                  operation,
    input  wire  [twr_pkg::CHAR_W-1:0]           char_code,
    input  wire  [twr_pkg::ROW_PORT_W-1:0]       read_row,
    input  wire  [twr_pkg::COL_PORT_W-1:0]       read_column,
    input  wire  twr_pkg::eng_status_t           status,
    output logic                                 head_valid,
    output twr_pkg::cmd_t                        head
);

    twr_pkg::cmd_t                      entry_reg [twr_pkg::QDEPTH];
    logic [twr_pkg::QPTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [twr_pkg::QPTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [twr_pkg::QCNT_W-1:0]         count_reg, count_next;
    twr_pkg::cmd_t                      cmd;
    logic                               push;

    // Classify the incoming item.
    always_comb
    begin
        cmd.char_code   = char_code;
        cmd.read_row    = read_row;
        cmd.read_column = read_column;
        if (operation == twr_pkg::OP_READ)
        begin
            if ((32'(read_row) < ROWS) && (32'(read_column) < COLUMNS))
            begin
                cmd.kind = twr_pkg::CMD_READ;
            end
            else
            begin
                cmd.kind = twr_pkg::CMD_READ_OUT;
            end
        end
        else
        begin
            unique case (char_code)
                twr_pkg::CH_NEWLINE,
                twr_pkg::CH_RETURN:    cmd.kind = twr_pkg::CMD_NEWLINE;
                twr_pkg::CH_TAB:       cmd.kind = twr_pkg::CMD_TAB;
                twr_pkg::CH_BACKSPACE: cmd.kind = twr_pkg::CMD_BACKSPACE;
                default:               cmd.kind = twr_pkg::CMD_PUT;
            endcase
        end
    end

    assign busy       = (count_reg == twr_pkg::QCNT_W'(twr_pkg::QDEPTH)) || status.clearing;
    assign push       = start && !busy;
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push       ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = status.pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + twr_pkg::QCNT_W'(push) - twr_pkg::QCNT_W'(status.pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/twr_back.sv =====
// Back end: owns the cursor and the cell store, executes queued commands,
// scrolls and produces results. Depends on twr_pkg and twr_ram.
`default_nettype none

module twr_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 head_valid,
    input  wire  twr_pkg::cmd_t                 head,
    input  wire  [twr_pkg::ATTR_W-1:0]          attr,
    output twr_pkg::eng_status_t                status,
    output logic                                done,
    output logic [$clog2(ROWS)-1:0]             cur_row,
    output logic [$clog2(COLUMNS)-1:0]          cur_col,
    output logic [twr_pkg::CELL_W-1:0]          cell_data,
    output logic                                scrolled
);

    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH  = ROWS * (2 ** COL_W);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    localparam int             ST_W     = 3;
    localparam logic [ST_W-1:0] ST_CLEAR = 3'd0;
    localparam logic [ST_W-1:0] ST_IDLE  = 3'd1;
    localparam logic [ST_W-1:0] ST_READ  = 3'd2;
    localparam logic [ST_W-1:0] ST_BS2   = 3'd3;
    localparam logic [ST_W-1:0] ST_COPY  = 3'd4;
    localparam logic [ST_W-1:0] ST_DRAIN = 3'd5;
    localparam logic [ST_W-1:0] ST_BLANK = 3'd6;

    logic [ST_W-1:0]            state_reg, state_next;
    logic [ROW_W-1:0]           row_reg, row_next;
    logic [COL_W-1:0]           col_reg, col_next;
    logic [ROW_W-1:0]           scan_row_reg, scan_row_next;
    logic [COL_W-1:0]           scan_col_reg, scan_col_next;
    logic [ADDR_W-1:0]          clr_addr_reg, clr_addr_next;
    logic                       wr_pend_reg, wr_pend_next;
    logic [ADDR_W-1:0]          wr_addr_reg, wr_addr_next;
    logic                       done_reg, done_next;
    logic [twr_pkg::CELL_W-1:0] cell_reg, cell_next;
    logic                       scrolled_reg, scrolled_next;

    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_waddr;
    logic [twr_pkg::CELL_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]          ram_raddr;
    logic [twr_pkg::CELL_W-1:0] ram_rdata;

    logic                       pop;
    logic                       advance;
    logic [COL_W:0]             tab_sum;
    logic [twr_pkg::CELL_W-1:0] blank_cell;

    twr_ram #(
        .WIDTH (twr_pkg::CELL_W),
        .DEPTH (DEPTH)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        scan_row_next = scan_row_reg;
        scan_col_next = scan_col_reg;
        clr_addr_next = clr_addr_reg;
        wr_pend_next  = 1'b0;
        wr_addr_next  = wr_addr_reg;
        done_next     = 1'b0;
        cell_next     = cell_reg;
        scrolled_next = scrolled_reg;
        pop           = 1'b0;
        advance       = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = wr_addr_reg;
        ram_wdata     = ram_rdata;
        ram_raddr     = {scan_row_reg, scan_col_reg};
        blank_cell    = {attr, twr_pkg::CH_SPACE};
        tab_sum       = {1'b0, col_reg} + (COL_W + 1)'(twr_pkg::TAB_STEP);

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = twr_pkg::RESET_CELL;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop           = 1'b1;
                    cell_next     = '0;
                    scrolled_next = 1'b0;
                    done_next     = 1'b1;
                    unique case (head.kind)
                        twr_pkg::CMD_PUT:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = {row_reg, col_reg};
                            ram_wdata = {attr, head.char_code};
                            if (col_reg == LAST_COL)
                            begin
                                col_next = '0;
                                advance  = 1'b1;
                            end
                            else
                            begin
                                col_next = col_reg + 1'b1;
                            end
                        end
                        twr_pkg::CMD_NEWLINE:
                        begin
                            col_next = '0;
                            advance  = 1'b1;
                        end
                        twr_pkg::CMD_TAB:
                        begin
                            if (tab_sum >= (COL_W + 1)'(COLUMNS))
                            begin
                                col_next = COL_W'(tab_sum - (COL_W + 1)'(COLUMNS));
                                advance  = 1'b1;
                            end
                            else
                            begin
                                col_next = COL_W'(tab_sum);
                            end
                        end
                        twr_pkg::CMD_BACKSPACE:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = {row_reg, col_reg};
                            ram_wdata = blank_cell;
                            if (col_reg != '0)
                            begin
                                col_next   = col_reg - 1'b1;
                                done_next  = 1'b0;
                                state_next = ST_BS2;
                            end
                        end
                        twr_pkg::CMD_READ:
                        begin
                            ram_raddr  = {ROW_W'(head.read_row), COL_W'(head.read_column)};
                            done_next  = 1'b0;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            // Out-of-range read: result with an empty cell.
                        end
                    endcase
                    // Stepping below the last row starts a scroll; its
                    // result comes out when the last row has been blanked.
                    if (advance)
                    begin
                        if (row_reg == LAST_ROW)
                        begin
                            done_next     = 1'b0;
                            scan_row_next = ROW_W'(1);
                            scan_col_next = '0;
                            state_next    = ST_COPY;
                        end
                        else
                        begin
                            row_next = row_reg + 1'b1;
                        end
                    end
                end
            end
            ST_READ:
            begin
                cell_next  = ram_rdata;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_BS2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = {row_reg, col_reg};
                ram_wdata  = blank_cell;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_COPY:
            begin
                // Read one row below, write it back one row up in the next cycle.
                ram_we       = wr_pend_reg;
                wr_pend_next = 1'b1;
                wr_addr_next = {scan_row_reg - ROW_W'(1), scan_col_reg};
                if (scan_col_reg == LAST_COL)
                begin
                    scan_col_next = '0;
                    if (scan_row_reg == LAST_ROW)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        scan_row_next = scan_row_reg + 1'b1;
                    end
                end
                else
                begin
                    scan_col_next = scan_col_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                ram_we        = wr_pend_reg;
                scan_col_next = '0;
                state_next    = ST_BLANK;
            end
            ST_BLANK:
            begin
                ram_we    = 1'b1;
                ram_waddr = {LAST_ROW, scan_col_reg};
                ram_wdata = blank_cell;
                if (scan_col_reg == LAST_COL)
                begin
                    done_next     = 1'b1;
                    scrolled_next = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    scan_col_next = scan_col_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            row_reg      <= '0;
            col_reg      <= '0;
            clr_addr_reg <= '0;
            wr_pend_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            clr_addr_reg <= clr_addr_next;
            wr_pend_reg  <= wr_pend_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_row_reg <= scan_row_next;
        scan_col_reg <= scan_col_next;
        wr_addr_reg  <= wr_addr_next;
        cell_reg     <= cell_next;
        scrolled_reg <= scrolled_next;
    end

    assign status.pop      = pop;
    assign status.clearing = (state_reg == ST_CLEAR);
    assign done            = done_reg;
    assign cur_row         = row_reg;
    assign cur_col         = col_reg;
    assign cell_data       = cell_reg;
    assign scrolled        = scrolled_reg;

endmodule

`default_nettype wire

// ===== hdl/text_mode_terminal_writer.sv =====
// Top level of the text-mode terminal writer: register port and wiring.
// Depends on twr_pkg, twr_front, twr_back (and through it twr_ram).
//
//  Channel   Signals                                         Beat taken when
//  --------  ----------------------------------------------  ----------------------------
//  command   start, busy, operation, char_code,              start high and busy low
//            read_row, read_column
//  result    done, cursor_row, cursor_column, cell_data,     every cycle done is high;
//            scrolled                                        the receiver cannot stall it
//  register  psel, penable, pwrite, paddr, pwdata,           psel, penable, pwrite and
//            prdata, pready                                  pready all high
//
// With an empty queue, a put, newline or tab leaves the two-entry command
// queue and is executed in the cycle after its command beat, and its result
// beat follows in the cycle after that. A read and a backspace away from
// column zero pass one more state first, ST_READ for the registered read of
// the cell store and ST_BS2 for the second blanked cell. A scroll copies the
// store one cell per cycle, reading a cell and writing it one row up in the
// next cycle, then blanks the last row; its result beat comes only after
// the last row is blanked, while the queue fills and busy rises. After reset
// the cell store is cleared one entry a cycle, all ROWS * 2**clog2(COLUMNS)
// entries (3200 at 80x25), with busy held high; register writes are taken
// throughout.
`default_nettype none

module text_mode_terminal_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire                                clk,
    input  wire                                rst_n,
    // Command channel.
    input  wire                                start,
    output logic                               busy,
    input  wire                                operation,
    input  wire  [twr_pkg::CHAR_W-1:0]         char_code,
    input  wire  [twr_pkg::ROW_PORT_W-1:0]     read_row,
    input  wire  [twr_pkg::COL_PORT_W-1:0]     read_column,
    // Result channel.
    output logic                               done,
    output logic [twr_pkg::ROW_PORT_W-1:0]     cursor_row,
    output logic [twr_pkg::COL_PORT_W-1:0]     cursor_column,
    output logic [twr_pkg::CELL_W-1:0]         cell_data,
    output logic                               scrolled,
    // Register port.
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [twr_pkg::PADDR_W-1:0]        paddr,
    input  wire  [twr_pkg::PDATA_W-1:0]        pwdata,
    output logic [twr_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);

    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLUMNS);

    logic [twr_pkg::ATTR_W-1:0]    attr_reg, attr_next;
    logic                          attr_sel;
    twr_pkg::eng_status_t          status;
    logic                          head_valid;
    twr_pkg::cmd_t                 head;
    logic [ROW_W-1:0]              cur_row;
    logic [COL_W-1:0]              cur_col;

    // The only register is the text attribute at byte address zero; writes
    // to any other word are ignored and read back as zero.
    assign pready   = 1'b1;
    assign attr_sel = (paddr[twr_pkg::PADDR_W-1:2] == twr_pkg::REG_ATTR);

    always_comb
    begin
        attr_next = attr_reg;
        if (psel && penable && pwrite && attr_sel)
        begin
            attr_next = pwdata[twr_pkg::ATTR_W-1:0];
        end
        prdata = attr_sel ? twr_pkg::PDATA_W'(attr_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= twr_pkg::RESET_ATTR;
        end
        else
        begin
            attr_reg <= attr_next;
        end
    end

    // The front end sorts each command beat into a kind and queues it.
    twr_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .char_code   (char_code),
        .read_row    (read_row),
        .read_column (read_column),
        .status      (status),
        .head_valid  (head_valid),
        .head        (head)
    );

    // The back end holds the cursor and the cell store and drives results.
    twr_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .attr       (attr_reg),
        .status     (status),
        .done       (done),
        .cur_row    (cur_row),
        .cur_col    (cur_col),
        .cell_data  (cell_data),
        .scrolled   (scrolled)
    );

    assign cursor_row    = twr_pkg::ROW_PORT_W'(cur_row);
    assign cursor_column = twr_pkg::COL_PORT_W'(cur_col);

endmodule

`default_nettype wire

// ===== bench/text_mode_terminal_writer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the text-mode terminal writer: drives put and read
// commands plus attribute register writes, predicts every result beat and checks it.
// Depends on twr_pkg and the text_mode_terminal_writer RTL.

module text_mode_terminal_writer_tb;

    import twr_pkg::*;

    localparam int COLS         = 80;
    localparam int ROWS         = 25;
    localparam int ITEM_TARGET  = 1350;
    // A scroll of the 80x25 store shifts rows 1 to 24 up a row and its result beat
    // comes only after the last row is blanked. Before the attribute changes
    // we also idle past the last owed beat, so that a stray late beat has time to show up.
    localparam int SCROLL_TAIL  = 2100;
    // The longest quiet stretch of a correct run is the clearing pass after
    // reset. The limit is several times that.
    localparam int STALL_LIMIT  = 20000;
    localparam int MAX_REPORTED = 100;
    localparam logic [PADDR_W-1:0] ATTR_ADDR = {REG_ATTR, 2'b00};

    // Expected contents of one result beat.
    typedef struct packed {
        logic [ROW_PORT_W-1:0] row;
        logic [COL_PORT_W-1:0] column;
        logic [CELL_W-1:0]     cell_word;
        logic                  scroll;
    } cursor_report_t;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  start       = 1'b0;
    logic                  operation   = OP_PUT;
    logic [CHAR_W-1:0]     char_code   = '0;
    logic [ROW_PORT_W-1:0] read_row    = '0;
    logic [COL_PORT_W-1:0] read_column = '0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [PADDR_W-1:0]    paddr       = '0;
    logic [PDATA_W-1:0]    pwdata      = '0;

    logic                  busy;
    logic                  done;
    logic [ROW_PORT_W-1:0] cursor_row;
    logic [COL_PORT_W-1:0] cursor_column;
    logic [CELL_W-1:0]     cell_data;
    logic                  scrolled;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    // Our own copy of the terminal: cell store, cursor and attribute register.
    logic [CELL_W-1:0] screen_copy [ROWS][COLS];
    int                cur_row;
    int                cur_col;
    logic [ATTR_W-1:0] attr_copy;

    // Results still owed by the block, oldest first.
    cursor_report_t awaited_reports[$];

    int items_accepted = 0;
    int error_count    = 0;
    int burst_left     = 0;
    int quiet_cycles   = 0;

    text_mode_terminal_writer #(
        .COLUMNS(COLS),
        .ROWS   (ROWS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .char_code    (char_code),
        .read_row     (read_row),
        .read_column  (read_column),
        .done         (done),
        .cursor_row   (cursor_row),
        .cursor_column(cursor_column),
        .cell_data    (cell_data),
        .scrolled     (scrolled),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Terminal prediction
    // ------------------------------------------------------------------

    // Move the cursor one row down. Below the last row the whole store shifts
    // up one row and the last row is blanked in the current attribute.
    function automatic logic step_down_row();
        cur_row++;
        if (cur_row < ROWS)
        begin
            return 1'b0;
        end
        for (int r = 0; r < ROWS - 1; r++)
        begin
            for (int c = 0; c < COLS; c++)
            begin
                screen_copy[r][c] = screen_copy[r + 1][c];
            end
        end
        for (int c = 0; c < COLS; c++)
        begin
            screen_copy[ROWS - 1][c] = {attr_copy, CH_SPACE};
        end
        cur_row = ROWS - 1;
        return 1'b1;
    endfunction

    // Apply one accepted command to the copy and return the beat it must produce.
    function automatic cursor_report_t apply_command(logic op, logic [CHAR_W-1:0] ch,
                                                     logic [ROW_PORT_W-1:0] rr,
                                                     logic [COL_PORT_W-1:0] rc);
        cursor_report_t rep;
        rep = '0;
        if (op == OP_READ)
        begin
            // Reads outside the store return zero.
            if (rr < ROWS && rc < COLS)
            begin
                rep.cell_word = screen_copy[rr][rc];
            end
        end
        else if (ch == CH_NEWLINE || ch == CH_RETURN)
        begin
            cur_col    = 0;
            rep.scroll = step_down_row();
        end
        else if (ch == CH_TAB)
        begin
            // A tab past the end carries its overshoot into the next row.
            cur_col += TAB_STEP;
            if (cur_col >= COLS)
            begin
                cur_col   -= COLS;
                rep.scroll = step_down_row();
            end
        end
        else if (ch == CH_BACKSPACE)
        begin
            // The current cell is always blanked; at column zero the cursor stays.
            screen_copy[cur_row][cur_col] = {attr_copy, CH_SPACE};
            if (cur_col > 0)
            begin
                cur_col--;
                screen_copy[cur_row][cur_col] = {attr_copy, CH_SPACE};
            end
        end
        else
        begin
            screen_copy[cur_row][cur_col] = {attr_copy, ch};
            cur_col++;
            if (cur_col >= COLS)
            begin
                cur_col    = 0;
                rep.scroll = step_down_row();
            end
        end
        rep.row    = ROW_PORT_W'(cur_row);
        rep.column = COL_PORT_W'(cur_col);
        return rep;
    endfunction

    // Shared comparison for every checked value.
    function automatic void check_field(string name, logic [31:0] expected,
                                        logic [31:0] actual);
        if (actual === expected)
        begin
            return;
        end
        error_count++;
        if (error_count <= MAX_REPORTED)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, expected, actual);
        end
    endfunction

    // A character picked for typing: mostly printable text, some arbitrary
    // bytes, and control codes at the given percentage.
    function automatic logic [CHAR_W-1:0] pick_char(int control_share);
        if ($urandom_range(0, 99) < control_share)
        begin
            case ($urandom_range(0, 3))
                0:       return CH_NEWLINE;
                1:       return CH_RETURN;
                2:       return CH_TAB;
                default: return CH_BACKSPACE;
            endcase
        end
        if ($urandom_range(0, 9) == 0)
        begin
            return CHAR_W'($urandom_range(0, 255));
        end
        return CHAR_W'($urandom_range(8'h20, 8'h7E));
    endfunction

    // ------------------------------------------------------------------
    // Command sender
    // ------------------------------------------------------------------

    // Send one command beat and record its expected result once it is taken.
    // Called at a rising edge. The sender works in bursts; between bursts start
    // may drop, and while it is low the payload ports carry junk, which the
    // block must ignore. Start is left high after the beat so that a following
    // command goes out back to back; every other path lowers it first.
    task automatic issue_command(logic op, logic [CHAR_W-1:0] ch,
                                 logic [ROW_PORT_W-1:0] rr, logic [COL_PORT_W-1:0] rc);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap)
                begin
                    operation   <= 1'($urandom);
                    char_code   <= CHAR_W'($urandom);
                    read_row    <= ROW_PORT_W'($urandom);
                    read_column <= COL_PORT_W'($urandom);
                    @(posedge clk);
                end
            end
        end
        burst_left--;
        start       <= 1'b1;
        operation   <= op;
        char_code   <= ch;
        read_row    <= rr;
        read_column <= rc;
        // The beat is taken at the first edge at which busy is low.
        do
            @(posedge clk);
        while (busy);
        awaited_reports.push_back(apply_command(op, ch, rr, rc));
        items_accepted++;
    endtask

    // A put carries junk in the unused read coordinates.
    task automatic put_char(logic [CHAR_W-1:0] ch);
        issue_command(OP_PUT, ch, ROW_PORT_W'($urandom), COL_PORT_W'($urandom));
    endtask

    // A read carries junk in the unused character field.
    task automatic read_cell(int r, int c);
        issue_command(OP_READ, CHAR_W'($urandom), ROW_PORT_W'(r), COL_PORT_W'(c));
    endtask

    // Bring the block to rest: stop sending, wait for every owed beat, then
    // idle a while longer so that a stray late beat would be caught.
    task automatic settle();
        start <= 1'b0;
        while (awaited_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SCROLL_TAIL) @(posedge clk);
    endtask

    // Write the attribute register, then read it back over the same port.
    task automatic set_text_attribute(logic [ATTR_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ATTR_ADDR;
        pwdata  <= {(PDATA_W - ATTR_W)'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        attr_copy = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        check_field("prdata", 32'(value), 32'(prdata[ATTR_W-1:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // The store must come out of reset as spaces in the reset attribute, and
    // reads outside the store must return zero.
    task automatic test_reset_screen();
        read_cell(0, 0);
        read_cell(ROWS - 1, COLS - 1);
        read_cell(ROWS, 0);
        read_cell(0, COLS);
        read_cell(31, 127);
    endtask

    // Lowest and highest character bytes with the all-ones attribute.
    task automatic test_glyph_extremes();
        settle();
        set_text_attribute(8'hFF);
        put_char(8'h00);
        put_char(8'hFF);
        put_char("A");
        read_cell(0, 0);
        read_cell(0, 1);
        read_cell(0, 2);
    endtask

    // Backspace in mid-row blanks two cells; at column zero it blanks one and
    // the cursor stays. Return and newline both start the next row.
    task automatic test_backspace_and_line_ends();
        settle();
        set_text_attribute(8'h00);
        put_char(CH_BACKSPACE);
        read_cell(0, 2);
        read_cell(0, 3);
        put_char(CH_RETURN);
        put_char(CH_BACKSPACE);
        read_cell(1, 0);
        put_char(CH_NEWLINE);
        put_char(CH_TAB);
        put_char(CH_TAB);
    endtask

    // One phase of random traffic under one attribute, until the running item
    // count reaches quota. Most of it is typed lines with read-back of the
    // cursor row; the rest is control bursts, scattered probes and runs of
    // tabs long enough to wrap the row.
    task automatic test_random_traffic(logic [ATTR_W-1:0] attr, int quota);
        settle();
        set_text_attribute(attr);
        while (items_accepted < quota)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    repeat ($urandom_range(1, 40)) put_char(pick_char(8));
                    if ($urandom_range(0, 1) == 1)
                    begin
                        repeat ($urandom_range(1, 4)) read_cell(cur_row, $urandom_range(0, COLS - 1));
                    end
                end
                5, 6:
                begin
                    repeat ($urandom_range(1, 8)) put_char(pick_char(100));
                end
                7, 8:
                begin
                    // The last row is where a scroll leaves its blanks.
                    repeat ($urandom_range(1, 6))
                    begin
                        case ($urandom_range(0, 3))
                            0:       read_cell(ROWS - 1, $urandom_range(0, COLS - 1));
                            1:       read_cell($urandom_range(0, 31), $urandom_range(0, 127));
                            default: read_cell($urandom_range(0, ROWS - 1),
                                               $urandom_range(0, COLS - 1));
                        endcase
                    end
                end
                default:
                begin
                    repeat ($urandom_range(1, 21)) put_char(CH_TAB);
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking: every done beat is taken, so each one is compared with
    // the oldest expectation. A beat with nothing owed is a failure.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cursor_report_t want;
        if (rst_n && done)
        begin
            if (awaited_reports.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTED)
                begin
                    $error("result beat with no command outstanding (row %0d column %0d)",
                           cursor_row, cursor_column);
                end
            end
            else
            begin
                want = awaited_reports.pop_front();
                check_field("cursor_row", 32'(want.row), 32'(cursor_row));
                check_field("cursor_column", 32'(want.column), 32'(cursor_column));
                check_field("cell_data", 32'(want.cell_word), 32'(cell_data));
                check_field("scrolled", 32'(want.scroll), 32'(scrolled));
            end
        end
    end

    // Watchdog: any beat on the command, result or register port counts as
    // progress; a long stretch without one ends the run as a failure.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable && pready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= STALL_LIMIT)
        begin
            $display("text_mode_terminal_writer_tb: errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Run sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            for (int c = 0; c < COLS; c++)
            begin
                screen_copy[r][c] = RESET_CELL;
            end
        end
        cur_row   = 0;
        cur_col   = 0;
        attr_copy = RESET_ATTR;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // The clearing pass after reset holds busy high; the first command
        // simply waits for it.
        test_reset_screen();
        test_glyph_extremes();
        test_backspace_and_line_ends();
        test_random_traffic(ATTR_W'($urandom_range(1, 254)), ITEM_TARGET / 4);
        test_random_traffic(8'h00, ITEM_TARGET / 2);
        test_random_traffic(8'hFF, 3 * ITEM_TARGET / 4);
        test_random_traffic(ATTR_W'($urandom_range(1, 254)), ITEM_TARGET);

        // Drain, then give a stray late beat time to show up.
        settle();
        if (error_count == 0)
        begin
            $display("text_mode_terminal_writer_tb: clean");
        end
        else
        begin
            $display("text_mode_terminal_writer_tb: errors");
        end
        $finish;
    end

endmodule
